[hw/rtl/ryp_pkg.sv]
package ryp_pkg;

    localparam int MAX_FRAME_PAIRS   = 524288;
    localparam int MAX_PAYLOAD_BYTES = 3072;

    localparam int FP_W   = 20;
    localparam int MP_W   = 12;
    localparam int PX_W   = 16;
    localparam int LEN_W  = 12;
    localparam int BYTE_W = 8;
    localparam int SUM_W  = 18;

    localparam int OFF_W   = $clog2(MAX_FRAME_PAIRS);
    localparam int MAX_CAP = (MAX_PAYLOAD_BYTES - 2) / 4;
    localparam int CAP_W   = $clog2(MAX_CAP + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = FP_W;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PAIRS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 1'd1;

    localparam logic [FP_W-1:0] RST_FRAME_PAIRS = 20'd38400;
    localparam logic [MP_W-1:0] RST_MAX_PAYLOAD = 12'd3072;
    localparam int MIN_PAYLOAD = 6;

    localparam logic [BYTE_W-1:0] HDR_LEN = 8'd2;

    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);

    // bt.601 coefficients
    localparam logic signed [SUM_W-1:0] C_Y_R   = 18'sd66;
    localparam logic signed [SUM_W-1:0] C_Y_G   = 18'sd129;
    localparam logic signed [SUM_W-1:0] C_Y_B   = 18'sd25;
    localparam logic signed [SUM_W-1:0] C_CB_R  = -18'sd38;
    localparam logic signed [SUM_W-1:0] C_CB_G  = -18'sd74;
    localparam logic signed [SUM_W-1:0] C_CB_B  = 18'sd112;
    localparam logic signed [SUM_W-1:0] C_CR_R  = 18'sd112;
    localparam logic signed [SUM_W-1:0] C_CR_G  = -18'sd94;
    localparam logic signed [SUM_W-1:0] C_CR_B  = -18'sd18;
    localparam logic signed [SUM_W-1:0] C_RND   = 18'sd128;
    localparam logic signed [SUM_W-1:0] C_Y_OFS = 18'sd16;
    localparam logic signed [SUM_W-1:0] C_C_OFS = 18'sd128;
    localparam logic signed [SUM_W-1:0] C_DIV_BIAS = 18'sd255;
    localparam logic signed [SUM_W-1:0] C_U8_MAX   = 18'sd255;

    typedef struct packed {
        logic             hdr;
        logic             fid;
        logic             eof;
        logic             last;
        logic [LEN_W-1:0] len;
        logic [PX_W-1:0]  px0;
        logic [PX_W-1:0]  px1;
    } t_entry;

    typedef struct packed {
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] cb;
        logic signed [SUM_W-1:0] cr;
    } t_sums;

    typedef struct packed {
        logic              is_header;
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b2;
        logic [BYTE_W-1:0] b3;
        logic              last;
        logic [LEN_W-1:0]  len;
    } t_result;

    function automatic logic [FP_W-1:0] f_clamp_fp(input logic [FP_W-1:0] d);
        logic [FP_W-1:0] v;
        v = d;
        if (d == '0) v = FP_W'(1);
        if (int'(d) > MAX_FRAME_PAIRS) v = FP_W'(MAX_FRAME_PAIRS);
        return v;
    endfunction

    // pairs that fit one packet after the header
    function automatic logic [CAP_W-1:0] f_cap(input logic [MP_W-1:0] d);
        logic [MP_W-1:0] mp;
        logic [MP_W-1:0] t;
        mp = d;
        if (int'(d) < MIN_PAYLOAD) mp = MP_W'(MIN_PAYLOAD);
        if (int'(d) > MAX_PAYLOAD_BYTES) mp = MP_W'(MAX_PAYLOAD_BYTES);
        t = mp - MP_W'(2);
        return CAP_W'(t >> 2);
    endfunction

    function automatic t_sums f_sums(input logic [PX_W-1:0] px);
        logic [4:0] r5;
        logic [5:0] g6;
        logic [4:0] b5;
        logic signed [SUM_W-1:0] r;
        logic signed [SUM_W-1:0] g;
        logic signed [SUM_W-1:0] b;
        t_sums s;
        r5 = px[15:11];
        g6 = px[10:5];
        b5 = px[4:0];
        r = $signed({10'd0, r5, r5[4:2]});
        g = $signed({10'd0, g6, g6[5:4]});
        b = $signed({10'd0, b5, b5[4:2]});
        s.y  = C_Y_R * r + C_Y_G * g + C_Y_B * b + C_RND;
        s.cb = C_CB_R * r + C_CB_G * g + C_CB_B * b + C_RND;
        s.cr = C_CR_R * r + C_CR_G * g + C_CR_B * b + C_RND;
        return s;
    endfunction

    // divide by 256 toward zero, add offset, clamp to a byte
    function automatic logic [BYTE_W-1:0] f_to_u8(input logic signed [SUM_W-1:0] v,
                                                 input logic signed [SUM_W-1:0] ofs);
        logic signed [SUM_W-1:0] q;
        logic signed [SUM_W-1:0] t;
        logic [BYTE_W-1:0] res;
        if (v < 0) q = (v + C_DIV_BIAS) >>> 8;
        else q = v >>> 8;
        t = q + ofs;
        if (t < 0) res = '0;
        else if (t > C_U8_MAX) res = '1;
        else res = t[BYTE_W-1:0];
        return res;
    endfunction

endpackage

[hw/rtl/ryp_front.sv]
module ryp_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ryp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ryp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_push,
    input  logic [ryp_pkg::PX_W-1:0]         i_px0,
    input  logic [ryp_pkg::PX_W-1:0]         i_px1,
    input  logic                             i_q_full,
    output logic                             o_q_push,
    output ryp_pkg::t_entry                  o_q_entry
);

    logic [ryp_pkg::FP_W-1:0]  r_fp;
    logic [ryp_pkg::CAP_W-1:0] r_cap;
    logic [ryp_pkg::OFF_W-1:0] r_off, n_off;
    logic [ryp_pkg::CAP_W-1:0] r_cnt, n_cnt;
    logic [ryp_pkg::CAP_W-1:0] r_pkt_pairs, n_pkt_pairs;
    logic                      r_pkt_eof, n_pkt_eof;
    logic                      r_fid, n_fid;

    logic                      accept;
    logic                      open;
    logic [ryp_pkg::FP_W-1:0]  off_ext;
    logic [ryp_pkg::FP_W-1:0]  rem;
    logic [ryp_pkg::CAP_W-1:0] new_pairs;
    logic                      new_eof;
    logic [ryp_pkg::CAP_W-1:0] cur_pairs;
    logic                      cur_eof;
    logic [ryp_pkg::CAP_W:0]   cnt_inc;
    logic                      last;

    always_comb begin
        accept  = i_push && !i_q_full;
        open    = (r_cnt == '0);
        off_ext = ryp_pkg::FP_W'(r_off);
        // an offset past the frame end closes the frame with one pair
        if (off_ext < r_fp) rem = r_fp - off_ext;
        else rem = ryp_pkg::FP_W'(1);
        if (ryp_pkg::FP_W'(r_cap) >= rem) begin
            new_pairs = ryp_pkg::CAP_W'(rem);
            new_eof   = 1'b1;
        end else begin
            new_pairs = r_cap;
            new_eof   = 1'b0;
        end
        cur_pairs = open ? new_pairs : r_pkt_pairs;
        cur_eof   = open ? new_eof : r_pkt_eof;
        cnt_inc   = {1'b0, r_cnt} + (ryp_pkg::CAP_W + 1)'(1);
        last      = (cnt_inc >= {1'b0, cur_pairs});

        n_off       = r_off;
        n_cnt       = r_cnt;
        n_pkt_pairs = r_pkt_pairs;
        n_pkt_eof   = r_pkt_eof;
        n_fid       = r_fid;
        if (accept) begin
            n_pkt_pairs = cur_pairs;
            n_pkt_eof   = cur_eof;
            if (last) begin
                n_cnt = '0;
                if (cur_eof) begin
                    n_off = '0;
                    n_fid = ~r_fid;
                end else begin
                    n_off = r_off + ryp_pkg::OFF_W'(1);
                end
            end else begin
                n_cnt = cnt_inc[ryp_pkg::CAP_W-1:0];
                n_off = r_off + ryp_pkg::OFF_W'(1);
            end
        end
    end

    always_comb begin
        o_q_push       = accept;
        o_q_entry.hdr  = open;
        o_q_entry.fid  = r_fid;
        o_q_entry.eof  = cur_eof;
        o_q_entry.last = last;
        o_q_entry.len  = ryp_pkg::LEN_W'({cur_pairs, 2'b10});
        o_q_entry.px0  = i_px0;
        o_q_entry.px1  = i_px1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fp        <= ryp_pkg::RST_FRAME_PAIRS;
            r_cap       <= ryp_pkg::f_cap(ryp_pkg::RST_MAX_PAYLOAD);
            r_off       <= '0;
            r_cnt       <= '0;
            r_pkt_pairs <= '0;
            r_pkt_eof   <= 1'b0;
            r_fid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ryp_pkg::CFG_FRAME_PAIRS: begin
                        r_fp <= ryp_pkg::f_clamp_fp(i_cfg_data[ryp_pkg::FP_W-1:0]);
                    end
                    ryp_pkg::CFG_MAX_PAYLOAD: begin
                        r_cap <= ryp_pkg::f_cap(i_cfg_data[ryp_pkg::MP_W-1:0]);
                    end
                endcase
            end
            r_off       <= n_off;
            r_cnt       <= n_cnt;
            r_pkt_pairs <= n_pkt_pairs;
            r_pkt_eof   <= n_pkt_eof;
            r_fid       <= n_fid;
        end
    end

    a_cnt_in_pkt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_cnt < r_pkt_pairs))
        else $error("packet pair count past packet size");

    a_fid_on_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fid != $past(r_fid)) |-> (r_off == '0 && r_cnt == '0))
        else $error("frame id changed outside a frame end");

endmodule

[hw/rtl/ryp_fifo.sv]
module ryp_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ryp_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output ryp_pkg::t_entry o_head
);

    ryp_pkg::t_entry             r_mem [ryp_pkg::Q_DEPTH];
    logic [ryp_pkg::Q_PTR_W-1:0] r_wr;
    logic [ryp_pkg::Q_PTR_W-1:0] r_rd;
    logic [ryp_pkg::Q_PTR_W:0]   r_cnt;
    logic                        do_push;
    logic                        do_pop;

    always_comb begin
        o_full  = (r_cnt == (ryp_pkg::Q_PTR_W + 1)'(ryp_pkg::Q_DEPTH));
        o_empty = (r_cnt == '0);
        o_head  = r_mem[r_rd];
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + ryp_pkg::Q_PTR_W'(1);
            if (do_pop) r_rd <= r_rd + ryp_pkg::Q_PTR_W'(1);
            r_cnt <= r_cnt + (ryp_pkg::Q_PTR_W + 1)'(do_push)
                           - (ryp_pkg::Q_PTR_W + 1)'(do_pop);
        end
    end

endmodule

[hw/rtl/ryp_back.sv]
module ryp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  ryp_pkg::t_entry  i_q_head,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output ryp_pkg::t_result o_result
);

    // issue control
    logic                          r_hdr_done;
    logic [ryp_pkg::OUT_PTR_W:0]   r_used;
    logic                          credit_ok;
    logic                          issue_hdr;
    logic                          issue_data;
    logic                          issue;

    // conversion stage
    logic                          r1_valid;
    logic                          r1_hdr;
    logic                          r1_fid;
    logic                          r1_eof;
    logic                          r1_last;
    logic [ryp_pkg::LEN_W-1:0]     r1_len;
    ryp_pkg::t_sums                r1_s0;
    ryp_pkg::t_sums                r1_s1;

    // result queue
    ryp_pkg::t_result              r_oq [ryp_pkg::OUT_DEPTH];
    logic [ryp_pkg::OUT_PTR_W-1:0] r_owr;
    logic [ryp_pkg::OUT_PTR_W-1:0] r_ord;
    logic [ryp_pkg::OUT_PTR_W:0]   r_ocnt;
    logic                          out_pop;

    ryp_pkg::t_result              res;
    logic [ryp_pkg::BYTE_W-1:0]    cb0, cb1, cr0, cr1;
    logic [ryp_pkg::BYTE_W:0]      cb_sum, cr_sum;

    always_comb begin
        // credits cover the conversion stage and the result queue
        credit_ok  = (r_used < (ryp_pkg::OUT_PTR_W + 1)'(ryp_pkg::OUT_DEPTH));
        issue_hdr  = !i_q_empty && i_q_head.hdr && !r_hdr_done && credit_ok;
        issue_data = !i_q_empty && (!i_q_head.hdr || r_hdr_done) && credit_ok;
        issue      = issue_hdr || issue_data;
        o_q_pop    = issue_data;
        out_pop    = i_pop && !o_empty;
    end

    always_comb begin
        cb0    = ryp_pkg::f_to_u8(r1_s0.cb, ryp_pkg::C_C_OFS);
        cb1    = ryp_pkg::f_to_u8(r1_s1.cb, ryp_pkg::C_C_OFS);
        cr0    = ryp_pkg::f_to_u8(r1_s0.cr, ryp_pkg::C_C_OFS);
        cr1    = ryp_pkg::f_to_u8(r1_s1.cr, ryp_pkg::C_C_OFS);
        cb_sum = {1'b0, cb0} + {1'b0, cb1};
        cr_sum = {1'b0, cr0} + {1'b0, cr1};
        res.is_header = r1_hdr;
        res.len       = r1_len;
        if (r1_hdr) begin
            res.b0   = ryp_pkg::HDR_LEN;
            res.b1   = {6'd0, r1_eof, r1_fid};
            res.b2   = '0;
            res.b3   = '0;
            res.last = 1'b0;
        end else begin
            res.b0   = ryp_pkg::f_to_u8(r1_s0.y, ryp_pkg::C_Y_OFS);
            res.b1   = cb_sum[ryp_pkg::BYTE_W:1];
            res.b2   = ryp_pkg::f_to_u8(r1_s1.y, ryp_pkg::C_Y_OFS);
            res.b3   = cr_sum[ryp_pkg::BYTE_W:1];
            res.last = r1_last;
        end
        o_empty  = (r_ocnt == '0);
        o_result = r_oq[r_ord];
    end

    always_ff @(posedge i_clk) begin
        r1_hdr  <= issue_hdr;
        r1_fid  <= i_q_head.fid;
        r1_eof  <= i_q_head.eof;
        r1_last <= i_q_head.last;
        r1_len  <= i_q_head.len;
        r1_s0   <= ryp_pkg::f_sums(i_q_head.px0);
        r1_s1   <= ryp_pkg::f_sums(i_q_head.px1);
        if (r1_valid) r_oq[r_owr] <= res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_done <= 1'b0;
            r_used     <= '0;
            r1_valid   <= 1'b0;
            r_owr      <= '0;
            r_ord      <= '0;
            r_ocnt     <= '0;
        end else begin
            if (issue_hdr) r_hdr_done <= 1'b1;
            else if (issue_data) r_hdr_done <= 1'b0;
            r_used   <= r_used + (ryp_pkg::OUT_PTR_W + 1)'(issue)
                               - (ryp_pkg::OUT_PTR_W + 1)'(out_pop);
            r1_valid <= issue;
            if (r1_valid) r_owr <= r_owr + ryp_pkg::OUT_PTR_W'(1);
            if (out_pop) r_ord <= r_ord + ryp_pkg::OUT_PTR_W'(1);
            r_ocnt   <= r_ocnt + (ryp_pkg::OUT_PTR_W + 1)'(r1_valid)
                               - (ryp_pkg::OUT_PTR_W + 1)'(out_pop);
        end
    end

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used <= (ryp_pkg::OUT_PTR_W + 1)'(ryp_pkg::OUT_DEPTH))
        && (r_ocnt <= r_used))
        else $error("result queue credit accounting broken");

    a_hdr_then_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue_hdr |=> (r_hdr_done && !i_q_empty && i_q_head.hdr))
        else $error("header issued without its data item held");

endmodule

[hw/rtl/rgb565_to_yuy2_packetizer_top.sv]
// datapath: an accepted pair goes through the input queue, the conversion stage
//   register and the result queue; a header item is issued ahead of its data item
// throughput: one pair per cycle while the queues have room; each packet header
//   takes an extra back-end issue slot, as one issue slot feeds the conversion stage
// reset: synchronous active low; clears queues, counters and frame id, and loads the
//   configuration defaults (38400 pairs per frame, 3072 byte payload)
module rgb565_to_yuy2_packetizer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ryp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ryp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [ryp_pkg::PX_W-1:0]       i_first_pixel,
    input  logic [ryp_pkg::PX_W-1:0]       i_second_pixel,
    output logic                           empty,
    input  logic                           pop,
    output logic                           o_is_header,
    output logic [ryp_pkg::BYTE_W-1:0]     o_byte_zero,
    output logic [ryp_pkg::BYTE_W-1:0]     o_byte_one,
    output logic [ryp_pkg::BYTE_W-1:0]     o_byte_two,
    output logic [ryp_pkg::BYTE_W-1:0]     o_byte_three,
    output logic                           o_last_in_packet,
    output logic [ryp_pkg::LEN_W-1:0]      o_packet_length
);

    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    ryp_pkg::t_entry  q_in;
    ryp_pkg::t_entry  q_head;
    ryp_pkg::t_result result;

    ryp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_px0      (i_first_pixel),
        .i_px1      (i_second_pixel),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_entry  (q_in)
    );

    ryp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    ryp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (result)
    );

    always_comb begin
        full             = q_full;
        o_is_header      = result.is_header;
        o_byte_zero      = result.b0;
        o_byte_one       = result.b1;
        o_byte_two       = result.b2;
        o_byte_three     = result.b3;
        o_last_in_packet = result.last;
        o_packet_length  = result.len;
    end

endmodule

[tb/yuy2_packet_checker.sv]
`timescale 1ns / 1ps

module yuy2_packet_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ryp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ryp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           push,
    input  logic                           full,
    input  logic [ryp_pkg::PX_W-1:0]       i_first_pixel,
    input  logic [ryp_pkg::PX_W-1:0]       i_second_pixel,
    input  logic                           empty,
    input  logic                           pop,
    input  logic                           i_is_header,
    input  logic [ryp_pkg::BYTE_W-1:0]     i_byte_zero,
    input  logic [ryp_pkg::BYTE_W-1:0]     i_byte_one,
    input  logic [ryp_pkg::BYTE_W-1:0]     i_byte_two,
    input  logic [ryp_pkg::BYTE_W-1:0]     i_byte_three,
    input  logic                           i_last_in_packet,
    input  logic [ryp_pkg::LEN_W-1:0]      i_packet_length,
    output int                             o_fail_count,
    output int                             o_pending
);
    import ryp_pkg::*;

    typedef struct packed {
        logic              is_header;
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b2;
        logic [BYTE_W-1:0] b3;
        logic              last;
        logic [LEN_W-1:0]  len;
    } t_yuy2_word;

    t_yuy2_word expected_words[$];
    int fail_count = 0;

    // shadow of the registers and of the packetizer state
    logic [FP_W-1:0]  frame_pairs_reg;
    logic [MP_W-1:0]  payload_reg;
    logic [OFF_W-1:0] frame_offset;
    int unsigned      pairs_in_packet;
    int unsigned      packet_size;
    logic             packet_ends_frame;
    logic             frame_id;

    assign o_fail_count = fail_count;

    function automatic logic [BYTE_W-1:0] sat_byte(input int v);
        if (v < 0) return '0;
        if (v > 255) return '1;
        return BYTE_W'(v);
    endfunction

    function automatic void rgb_to_ycc(input logic [PX_W-1:0] px,
                                       output logic [BYTE_W-1:0] y,
                                       output logic [BYTE_W-1:0] cb,
                                       output logic [BYTE_W-1:0] cr);
        int r;
        int g;
        int b;
        r = int'({px[15:11], px[15:13]});
        g = int'({px[10:5], px[10:9]});
        b = int'({px[4:0], px[4:2]});
        // int division truncates toward zero
        y  = sat_byte((66 * r + 129 * g + 25 * b + 128) / 256 + 16);
        cb = sat_byte((-38 * r - 74 * g + 112 * b + 128) / 256 + 128);
        cr = sat_byte((112 * r - 94 * g - 18 * b + 128) / 256 + 128);
    endfunction

    task automatic packetize_pair(input logic [PX_W-1:0] px0, input logic [PX_W-1:0] px1);
        int unsigned pay;
        int unsigned frame;
        int unsigned cap;
        int unsigned rem;
        logic [BYTE_W-1:0] y0, cb0, cr0, y1, cb1, cr1;
        t_yuy2_word w;
        if (pairs_in_packet == 0) begin
            pay = payload_reg;
            frame = frame_pairs_reg;
            if (pay < MIN_PAYLOAD) pay = MIN_PAYLOAD;
            if (pay > MAX_PAYLOAD_BYTES) pay = MAX_PAYLOAD_BYTES;
            if (frame < 1) frame = 1;
            if (frame > MAX_FRAME_PAIRS) frame = MAX_FRAME_PAIRS;
            cap = (pay - 2) / 4;
            // offset already past the frame end: a single-pair closing packet
            rem = (frame_offset < frame) ? frame - frame_offset : 1;
            packet_ends_frame = (cap >= rem);
            packet_size = packet_ends_frame ? rem : cap;
            w.is_header = 1'b1;
            w.b0 = HDR_LEN;
            w.b1 = {6'd0, packet_ends_frame, frame_id};
            w.b2 = '0;
            w.b3 = '0;
            w.last = 1'b0;
            w.len = LEN_W'(2 + 4 * packet_size);
            expected_words.push_back(w);
        end
        rgb_to_ycc(px0, y0, cb0, cr0);
        rgb_to_ycc(px1, y1, cb1, cr1);
        pairs_in_packet++;
        frame_offset++;
        w.is_header = 1'b0;
        w.b0 = y0;
        w.b1 = BYTE_W'((int'(cb0) + int'(cb1)) / 2);
        w.b2 = y1;
        w.b3 = BYTE_W'((int'(cr0) + int'(cr1)) / 2);
        w.last = (pairs_in_packet >= packet_size);
        w.len = LEN_W'(2 + 4 * packet_size);
        expected_words.push_back(w);
        if (w.last) begin
            pairs_in_packet = 0;
            if (packet_ends_frame) begin
                frame_offset = '0;
                frame_id = ~frame_id;
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_yuy2_word w;
        if (!i_rst_n) begin
            frame_pairs_reg = RST_FRAME_PAIRS;
            payload_reg = RST_MAX_PAYLOAD;
            frame_offset = '0;
            pairs_in_packet = 0;
            packet_size = 0;
            packet_ends_frame = 1'b0;
            frame_id = 1'b0;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_FRAME_PAIRS) frame_pairs_reg = i_cfg_data[FP_W-1:0];
                else if (i_cfg_idx == CFG_MAX_PAYLOAD) payload_reg = i_cfg_data[MP_W-1:0];
            end
            if (push && !full) packetize_pair(i_first_pixel, i_second_pixel);
            if (pop && !empty) begin
                if (expected_words.size() == 0) begin
                    $error("result item with nothing expected");
                    fail_count++;
                end else begin
                    w = expected_words.pop_front();
                    check_field("is_header", w.is_header, i_is_header);
                    check_field("byte_zero", w.b0, i_byte_zero);
                    check_field("byte_one", w.b1, i_byte_one);
                    check_field("byte_two", w.b2, i_byte_two);
                    check_field("byte_three", w.b3, i_byte_three);
                    check_field("last_in_packet", w.last, i_last_in_packet);
                    check_field("packet_length", w.len, i_packet_length);
                end
            end
        end
        o_pending <= expected_words.size();
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import ryp_pkg::*;

    localparam int TARGET_PAIRS   = 1550;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int N_DIRECTED     = 16;
    localparam int N_EXTREMES     = 8;

    localparam logic [PX_W-1:0] DIR_FIRST [N_DIRECTED] = '{
        16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 16'hF800, 16'h07E0, 16'hFFE0,
        16'h0821, 16'h8410, 16'hAAAA, 16'h5555, 16'hF81F, 16'h001F, 16'h0001, 16'hFFFF};
    localparam logic [PX_W-1:0] DIR_SECOND [N_DIRECTED] = '{
        16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 16'h001F, 16'hF81F, 16'h001F,
        16'h0841, 16'h7BEF, 16'h5555, 16'hAAAA, 16'h07E0, 16'hFFE0, 16'h8000, 16'h0000};

    // register corner settings; some payload words carry junk above bit 11
    localparam logic [CFG_DATA_W-1:0] EXT_FRAME [N_EXTREMES] = '{
        20'd0, 20'd1, 20'hFFFFF, 20'd524288, 20'd524289, 20'd3, 20'd2, 20'd40};
    localparam logic [CFG_DATA_W-1:0] EXT_PAYLOAD [N_EXTREMES] = '{
        20'd0, 20'd5, 20'hFFFFF, 20'd3072, 20'd3073, 20'd6, 20'd9, 20'hAB00A};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_FRAME_PAIRS;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  push = 1'b0;
    logic                  full;
    logic [PX_W-1:0]       i_first_pixel = '0;
    logic [PX_W-1:0]       i_second_pixel = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic                  o_is_header;
    logic [BYTE_W-1:0]     o_byte_zero;
    logic [BYTE_W-1:0]     o_byte_one;
    logic [BYTE_W-1:0]     o_byte_two;
    logic [BYTE_W-1:0]     o_byte_three;
    logic                  o_last_in_packet;
    logic [LEN_W-1:0]      o_packet_length;

    int fail_count;
    int pending_words;
    int pairs_sent = 0;
    int burst_left = 1;
    bit sender_steady = 1'b0;
    int quiet_cycles = 0;

    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_stall_left = 0;
    int rx_tick = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    rgb565_to_yuy2_packetizer_top DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .push(push),
        .full(full),
        .i_first_pixel(i_first_pixel),
        .i_second_pixel(i_second_pixel),
        .empty(empty),
        .pop(pop),
        .o_is_header(o_is_header),
        .o_byte_zero(o_byte_zero),
        .o_byte_one(o_byte_one),
        .o_byte_two(o_byte_two),
        .o_byte_three(o_byte_three),
        .o_last_in_packet(o_last_in_packet),
        .o_packet_length(o_packet_length)
    );

    yuy2_packet_checker u_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .push(push),
        .full(full),
        .i_first_pixel(i_first_pixel),
        .i_second_pixel(i_second_pixel),
        .empty(empty),
        .pop(pop),
        .i_is_header(o_is_header),
        .i_byte_zero(o_byte_zero),
        .i_byte_one(o_byte_one),
        .i_byte_two(o_byte_two),
        .i_byte_three(o_byte_three),
        .i_last_in_packet(o_last_in_packet),
        .i_packet_length(o_packet_length),
        .o_fail_count(fail_count),
        .o_pending(pending_words)
    );

    // receiver: switches between free flow, random, periodic and long stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            rx_tick++;
            if (rx_mode_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(50, 300);
                rx_stall_left = 0;
            end
            rx_mode_left--;
            case (rx_mode)
                0: begin
                    pop <= 1'b1;
                end
                1: begin
                    pop <= ($urandom_range(0, 9) < 7);
                end
                2: begin
                    pop <= (rx_tick % 5 != 0);
                end
                default: begin
                    if (rx_stall_left > 0) begin
                        pop <= 1'b0;
                        rx_stall_left--;
                    end else begin
                        pop <= 1'b1;
                        if ($urandom_range(0, 7) == 0) rx_stall_left = $urandom_range(5, 25);
                    end
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [PX_W-1:0] rand_pixel();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return PX_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_frame_pairs();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_DATA_W'($urandom_range(524288, 1048575));
            2: return CFG_DATA_W'($urandom_range(41, 2000));
            default: return CFG_DATA_W'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_payload();
        logic [MP_W-1:0] mp;
        case ($urandom_range(0, 9))
            0: mp = MP_W'($urandom_range(0, 5));
            1: mp = MP_W'($urandom_range(3072, 4095));
            2: mp = MP_W'($urandom_range(41, 600));
            default: mp = MP_W'($urandom_range(6, 40));
        endcase
        return {8'($urandom_range(0, 255)), mp};
    endfunction

    task automatic send_pair(input logic [PX_W-1:0] px0, input logic [PX_W-1:0] px1);
        int gap;
        push <= 1'b1;
        i_first_pixel <= px0;
        i_second_pixel <= px1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        pairs_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = sender_steady ? 0 : $urandom_range(0, 8);
            // push only drops when a real gap follows
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input bit wr_frame, input logic [CFG_DATA_W-1:0] frame_val,
                              input bit wr_payload, input logic [CFG_DATA_W-1:0] pay_val);
        if (wr_frame) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= CFG_FRAME_PAIRS;
            i_cfg_data <= frame_val;
            @(posedge i_clk);
        end
        if (wr_payload) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= CFG_MAX_PAYLOAD;
            i_cfg_data <= pay_val;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_random(input int count);
        sender_steady = ($urandom_range(0, 3) == 0);
        repeat (count) send_pair(rand_pixel(), rand_pixel());
    endtask

    initial begin
        int sel;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // color corners at the reset settings
        for (int k = 0; k < N_DIRECTED; k++) send_pair(DIR_FIRST[k], DIR_SECOND[k]);
        // fill out the first full-size packet left open by the reset settings
        send_random(MAX_CAP - N_DIRECTED);
        wait_drained();

        // shrink the frame below the current offset: next packet closes the frame
        write_regs(1'b1, 20'd5, 1'b1, 20'd10);
        send_random(12);
        wait_drained();

        for (int k = 0; k < N_EXTREMES; k++) begin
            write_regs(1'b1, EXT_FRAME[k], 1'b1, EXT_PAYLOAD[k]);
            send_random($urandom_range(6, 20));
            wait_drained();
        end

        while (pairs_sent < TARGET_PAIRS) begin
            sel = $urandom_range(0, 3);
            write_regs(sel != 1, rand_frame_pairs(), sel != 0, rand_payload());
            send_random($urandom_range(5, 60));
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
